// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/pawa_pkg.sv -----
// Shared constants of the pitot airspeed window average block.
package pawa_pkg;

  // Field widths
  localparam int SAMPLE_W = 12;
  localparam int SCALE_W  = 16;
  localparam int SPEED_W  = 14;
  localparam int PROD_W   = SAMPLE_W + SCALE_W;
  localparam int ROOT_W   = PROD_W / 2;
  localparam int IN_W     = 16;
  localparam int OUT_W    = 32;
  localparam int CFG_W    = 32;
  localparam int PADDR_W  = 3;

  // Largest speed the square root can give for a 12-bit difference
  localparam logic [SPEED_W-1:0] SPEED_MAX = 14'd16381;

  // Defaults
  localparam int                 WINDOW_DEF  = 20;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd5280;

  // Item kinds carried in tuser
  localparam logic ACT_SAMPLE    = 1'b0;
  localparam logic ACT_CALIBRATE = 1'b1;

  // Register index taken from paddr bit 2
  localparam logic REG_SPEED_SCALE = 1'b0;

endpackage

// ----- rtl/pitot_airspeed_window_average_top.sv -----
// Pitot airspeed window average: sample window, offset calibration, speed.
//
//  channel | ports  | payload
//  --------+--------+----------------------------------------------------
//  input   | in_*   | tuser[0] action, tdata[11:0] sample
//  result  | out_*  | tdata[13:0] speed, tdata[25:14] zero_offset
//  config  | cfg_*  | byte 0: speed_scale [15:0]
//
// One item at a time. A sample beat runs read, update, mean, multiply and
// square root; a calibrate beat runs the divide, then mean, multiply and
// square root, skipping the divide when no entry is nonzero. in_tready rises
// with out_tvalid. The one-bit-per-cycle divide by the nonzero count and the
// two-bits-per-cycle square root are the serial steps; the window mean is a
// reciprocal multiply. Reset clears the window through per-entry valid bits.
// A result waiting on out_tready holds; the next beat is taken meanwhile.
module pitot_airspeed_window_average_top
  import pawa_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [IN_W-1:0]    in_tdata,    // [11:0] sample
  input  logic [0:0]         in_tuser,    // [0] action
  // result channel
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [OUT_W-1:0]   out_tdata,   // [13:0] speed, [25:14] zero_offset
  // configuration port
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [CFG_W-1:0]   cfg_pwdata,
  output logic [CFG_W-1:0]   cfg_prdata,
  output logic               cfg_pready
);

  localparam int SLOT_W   = $clog2(WINDOW);
  localparam int CNT_W    = $clog2(WINDOW + 1);
  localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW);
  localparam int DSTEP_W  = $clog2(SUM_W);
  localparam int SQSTEP_W = $clog2(ROOT_W);
  localparam int SQREM_W  = ROOT_W + 3;
  localparam int RECIP_W  = SUM_W + 1;
  localparam int MEAN_SH  = SUM_W + $clog2(WINDOW);
  localparam int MPROD_W  = SUM_W + RECIP_W;

  localparam logic [SLOT_W-1:0]   SLOT_LAST  = SLOT_W'(WINDOW - 1);
  localparam logic [DSTEP_W-1:0]  DSTEP_TOP  = DSTEP_W'(SUM_W - 1);
  localparam logic [SQSTEP_W-1:0] SQSTEP_TOP = SQSTEP_W'(ROOT_W - 1);
  // ceil(2^MEAN_SH / WINDOW): exact floor division for any SUM_W-bit sum
  localparam logic [RECIP_W-1:0]  MEAN_RECIP =
    RECIP_W'(((1 << MEAN_SH) + WINDOW - 1) / WINDOW);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_READ = 4'd1;
  localparam logic [3:0] S_UPD  = 4'd2;
  localparam logic [3:0] S_DIVC = 4'd3;
  localparam logic [3:0] S_MEAN = 4'd4;
  localparam logic [3:0] S_MULT = 4'd5;
  localparam logic [3:0] S_SQRT = 4'd6;
  localparam logic [3:0] S_DONE = 4'd7;

  // Window memory and its valid bits
  logic [SAMPLE_W-1:0] win_mem [WINDOW];
  logic [WINDOW-1:0]   valid_r, valid_nxt;
  logic [SAMPLE_W-1:0] rd_data_r;
  logic                rd_en;
  logic                wr_en;

  logic [3:0]          state_r, state_nxt;
  logic [SAMPLE_W-1:0] smp_r, smp_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SAMPLE_W-1:0] offset_r, offset_nxt;
  logic [SCALE_W-1:0]  scale_r, scale_nxt;

  // Divider
  logic [CNT_W-1:0]    den_r, den_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;
  logic [SUM_W-1:0]    quo_r, quo_nxt;
  logic [DSTEP_W-1:0]  dstep_r, dstep_nxt;
  logic [SAMPLE_W-1:0] mean_r, mean_nxt;

  // Square root
  logic [PROD_W-1:0]   sq_val_r, sq_val_nxt;
  logic [SQREM_W-1:0]  sq_rem_r, sq_rem_nxt;
  logic [ROOT_W-1:0]   root_r, root_nxt;
  logic [SQSTEP_W-1:0] sqstep_r, sqstep_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]    out_data_r, out_data_nxt;

  // Combinational helpers
  logic                in_fire;
  logic                cfg_wr;
  logic [SAMPLE_W-1:0] old_smp;
  logic [SUM_W-1:0]    sum_upd;
  logic [CNT_W:0]      div_tmp;
  logic                div_bit;
  logic [SUM_W-1:0]    quo_step;
  logic [MPROD_W-1:0]  mean_prod;
  logic [SAMPLE_W-1:0] diff;
  logic [SQREM_W-1:0]  sq_tmp;
  logic [SQREM_W-1:0]  sq_trial;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_SPEED_SCALE) ?
                      {{(CFG_W-SCALE_W){1'b0}}, scale_r} : '0;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign rd_en = (state_r == S_READ);
  assign wr_en = (state_r == S_UPD);

  // Old entry reads as zero until written once after reset
  assign old_smp = valid_r[slot_r] ? rd_data_r : '0;
  assign sum_upd = sum_r - SUM_W'(old_smp) + SUM_W'(smp_r);

  // One restoring divide step
  assign div_tmp  = {rem_r, quo_r[SUM_W-1]};
  assign div_bit  = (div_tmp >= {1'b0, den_r});
  assign quo_step = {quo_r[SUM_W-2:0], div_bit};

  // Window mean by reciprocal multiply
  assign mean_prod = MPROD_W'(sum_r) * MPROD_W'(MEAN_RECIP);

  assign diff = (mean_r >= offset_r) ? (mean_r - offset_r) : (offset_r - mean_r);

  // One square root step, two radicand bits a cycle
  assign sq_tmp   = {sq_rem_r[SQREM_W-3:0], sq_val_r[PROD_W-1:PROD_W-2]};
  assign sq_trial = {{(SQREM_W-ROOT_W-2){1'b0}}, root_r, 2'b01};

  // Window memory: registered read, single write port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= win_mem[slot_r];
    end
    if (wr_en) begin
      win_mem[slot_r] <= smp_r;
    end
  end

  // Next state and datapath
  always_comb begin
    state_nxt     = state_r;
    smp_nxt       = smp_r;
    slot_nxt      = slot_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    offset_nxt    = offset_r;
    scale_nxt     = scale_r;
    valid_nxt     = valid_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    dstep_nxt     = dstep_r;
    mean_nxt      = mean_r;
    sq_val_nxt    = sq_val_r;
    sq_rem_nxt    = sq_rem_r;
    root_nxt      = root_r;
    sqstep_nxt    = sqstep_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    // Register write
    if (cfg_wr && (cfg_paddr[2] == REG_SPEED_SCALE)) begin
      scale_nxt = cfg_pwdata[SCALE_W-1:0];
    end

    // Drop the result once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          smp_nxt = in_tdata[SAMPLE_W-1:0];
          if (in_tuser[0] == ACT_SAMPLE) begin
            state_nxt = S_READ;
          end else if (cnt_r == '0) begin
            offset_nxt = '0;
            state_nxt  = S_MEAN;
          end else begin
            rem_nxt   = '0;
            quo_nxt   = sum_r;
            den_nxt   = cnt_r;
            dstep_nxt = DSTEP_TOP;
            state_nxt = S_DIVC;
          end
        end
      end
      S_READ: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        // Replace the oldest entry, then take the mean of the new sum
        sum_nxt = sum_upd;
        cnt_nxt = cnt_r + CNT_W'(smp_r != '0) - CNT_W'(old_smp != '0);
        valid_nxt[slot_r] = 1'b1;
        slot_nxt  = (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;
        state_nxt = S_MEAN;
      end
      S_DIVC: begin
        rem_nxt   = div_bit ? CNT_W'(div_tmp - {1'b0, den_r}) : div_tmp[CNT_W-1:0];
        quo_nxt   = quo_step;
        dstep_nxt = dstep_r - 1'b1;
        if (dstep_r == '0) begin
          offset_nxt = quo_step[SAMPLE_W-1:0];
          state_nxt  = S_MEAN;
        end
      end
      S_MEAN: begin
        mean_nxt  = mean_prod[MEAN_SH +: SAMPLE_W];
        state_nxt = S_MULT;
      end
      S_MULT: begin
        sq_val_nxt = PROD_W'(diff) * PROD_W'(scale_r);
        sq_rem_nxt = '0;
        root_nxt   = '0;
        sqstep_nxt = SQSTEP_TOP;
        state_nxt  = S_SQRT;
      end
      S_SQRT: begin
        sq_val_nxt = {sq_val_r[PROD_W-3:0], 2'b00};
        if (sq_tmp >= sq_trial) begin
          sq_rem_nxt = sq_tmp - sq_trial;
          root_nxt   = {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          sq_rem_nxt = sq_tmp;
          root_nxt   = {root_r[ROOT_W-2:0], 1'b0};
        end
        sqstep_nxt = sqstep_r - 1'b1;
        if (sqstep_r == '0) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // Hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{(OUT_W-SPEED_W-SAMPLE_W){1'b0}}, offset_r,
                           root_r[SPEED_W-1:0]};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_r      <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
      offset_r    <= '0;
      scale_r     <= SCALE_RESET;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      offset_r    <= offset_nxt;
      scale_r     <= scale_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    smp_r      <= smp_nxt;
    den_r      <= den_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    dstep_r    <= dstep_nxt;
    mean_r     <= mean_nxt;
    sq_val_r   <= sq_val_nxt;
    sq_rem_r   <= sq_rem_nxt;
    root_r     <= root_nxt;
    sqstep_r   <= sqstep_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ----- rtl/pawa_checker.sv -----
// Port-level checker for the pitot airspeed window average block, with bind.
`include "assert_macros.svh"

module pawa_checker
  import pawa_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // A stalled result beat holds its payload
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result beat changed while stalled")

  // One beat in work at a time
  `ASSERT_CLK(a_one_item, clk, rst_n, in_tvalid && in_tready |=> !in_tready, "input taken while a beat is in work")

  // Square root of a 12-bit by 16-bit product stays in range
  `ASSERT_CLK(a_speed_max, clk, rst_n, out_tvalid |-> out_tdata[SPEED_W-1:0] <= SPEED_MAX, "speed above its largest value")

  // Padding above the fields stays zero
  `ASSERT_CLK(a_pad_zero, clk, rst_n, out_tvalid |-> out_tdata[OUT_W-1:SPEED_W+SAMPLE_W] == '0, "result padding not zero")

  // Reset drops any pending result
  `ASSERT_ALWAYS(a_reset_clear, clk, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind pitot_airspeed_window_average_top pawa_checker u_pawa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- tb/tb_pitot_airspeed_window_average_top.sv -----
// Self-checking testbench for the pitot airspeed window average block.
module tb_pitot_airspeed_window_average_top;
  import pawa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN          = WINDOW_DEF;
  localparam int STALL_LIMIT  = 5000;
  localparam int SETTLE_CYC   = 60;
  localparam int HOLD_CYC     = 600;
  localparam int SAMPLE_MAX   = 4095;

  // Byte addresses of register index 0 and of an unused index
  localparam logic [PADDR_W-1:0] ADDR_SPEED_SCALE = {REG_SPEED_SCALE, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_UNUSED      = {~REG_SPEED_SCALE, 2'b00};

  typedef struct packed {
    logic [SPEED_W-1:0]  speed;
    logic [SAMPLE_W-1:0] zero_offset;
  } airspeed_reading_t;

  logic               clk;
  logic               rst_n       = 1'b0;
  logic               in_tvalid   = 1'b0;
  logic               in_tready;
  logic [IN_W-1:0]    in_tdata    = '0;   // [11:0] sample, [15:12] fill
  logic [0:0]         in_tuser    = '0;   // [0] action
  logic               out_tvalid;
  logic               out_tready  = 1'b0;
  logic [OUT_W-1:0]   out_tdata;          // [13:0] speed, [25:14] zero_offset
  logic               cfg_psel    = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite  = 1'b0;
  logic [PADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_W-1:0]   cfg_pwdata  = '0;
  logic [CFG_W-1:0]   cfg_prdata;
  logic               cfg_pready;

  pitot_airspeed_window_average_top dut (.*);

  // Predictor state
  logic [SAMPLE_W-1:0] win_entries [WIN];
  int unsigned         win_slot;
  logic [16:0]         win_sum;
  logic [4:0]          win_nonzero;
  logic [SAMPLE_W-1:0] offset_level;
  logic [SCALE_W-1:0]  scale_level;

  airspeed_reading_t pending_readings [$];
  int                error_count   = 0;
  int                in_idle_pct   = 0;
  int                out_stall_pct = 0;
  int                hold_asked    = 0;
  int                hold_taken    = 0;
  int                hold_left     = 0;
  int                quiet_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Integer square root, rounded down, built one result bit at a time
  function automatic logic [SPEED_W-1:0] floor_root(input logic [PROD_W-1:0] v);
    logic [SPEED_W-1:0] r;
    logic [SPEED_W-1:0] t;
    r = '0;
    for (int b = SPEED_W - 1; b >= 0; b--) begin
      t = r | (SPEED_W'(1) << b);
      if (PROD_W'(t) * PROD_W'(t) <= v) r = t;
    end
    return r;
  endfunction

  function automatic void clear_airspeed_state();
    for (int i = 0; i < WIN; i++) win_entries[i] = '0;
    win_slot     = 0;
    win_sum      = '0;
    win_nonzero  = '0;
    offset_level = '0;
    scale_level  = SCALE_RESET;
  endfunction

  // Apply one beat to the predictor and return the reading it must produce
  function automatic airspeed_reading_t advance_airspeed(input logic act,
                                                         input logic [SAMPLE_W-1:0] smp);
    airspeed_reading_t   rd;
    logic [SAMPLE_W-1:0] prev;
    logic [16:0]         mean;
    logic [SAMPLE_W-1:0] diff;
    if (act == ACT_SAMPLE) begin
      prev    = win_entries[win_slot];
      win_sum = win_sum - prev + smp;
      if (prev != 0) win_nonzero--;
      if (smp != 0) win_nonzero++;
      win_entries[win_slot] = smp;
      win_slot = (win_slot == WIN - 1) ? 0 : win_slot + 1;
    end else begin
      offset_level = (win_nonzero == 0) ? '0 : SAMPLE_W'(win_sum / win_nonzero);
    end
    mean = 17'(win_sum / WIN);
    diff = (mean >= offset_level) ? SAMPLE_W'(mean - offset_level)
                                  : SAMPLE_W'(offset_level - mean);
    rd.speed       = floor_root(PROD_W'(diff) * PROD_W'(scale_level));
    rd.zero_offset = offset_level;
    return rd;
  endfunction

  // Offer one beat after a random gap; predict it once it is taken
  task automatic send_beat(input logic act, input logic [SAMPLE_W-1:0] smp,
                           input logic [IN_W-SAMPLE_W-1:0] fill = '0);
    int gap;
    gap = 0;
    while ($urandom_range(99) < in_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {fill, smp};
    in_tuser  <= act;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_readings.push_back(advance_airspeed(act, smp));
  endtask

  task automatic stop_sending();
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    stop_sending();
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [PADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (addr[2] == REG_SPEED_SCALE) scale_level = value[SCALE_W-1:0];
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_check_scale();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= ADDR_SPEED_SCALE;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata[SCALE_W-1:0] !== scale_level) begin
      $error("speed_scale: expected %0d, actual %0d", scale_level, cfg_prdata[SCALE_W-1:0]);
      error_count++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_scale(input logic [CFG_W-1:0] value);
    wait_drained();
    cfg_write(ADDR_SPEED_SCALE, value);
    cfg_check_scale();
  endtask

  // Mixed traffic: steady runs with calibration, extreme and zero runs, noise, calibrate bursts
  task automatic run_traffic(input int n_items);
    int sent;
    int mode;
    int len;
    int base;
    int jit;
    int val;
    sent = 0;
    while (sent < n_items) begin
      mode = $urandom_range(9);
      if (mode <= 5) begin
        len  = $urandom_range(1, 24);
        base = ($urandom_range(3) == 0) ? ($urandom_range(1) ? SAMPLE_MAX : 0)
                                        : $urandom_range(SAMPLE_MAX);
        jit  = $urandom_range(15);
        for (int i = 0; i < len; i++) begin
          val = base + $urandom_range(2 * jit) - jit;
          if (val < 0) val = 0;
          if (val > SAMPLE_MAX) val = SAMPLE_MAX;
          send_beat(ACT_SAMPLE, SAMPLE_W'(val));
        end
        sent += len;
        if ($urandom_range(1)) begin
          send_beat(ACT_CALIBRATE, SAMPLE_W'($urandom()));
          sent++;
        end
      end else if (mode <= 7) begin
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++)
          send_beat(($urandom_range(3) == 0) ? ACT_CALIBRATE : ACT_SAMPLE,
                    SAMPLE_W'($urandom()));
        sent += len;
      end else if (mode == 8) begin
        len = $urandom_range(1, 25);
        for (int i = 0; i < len; i++) send_beat(ACT_SAMPLE, '0);
        send_beat(ACT_CALIBRATE, SAMPLE_W'($urandom()));
        sent += len + 1;
      end else begin
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) send_beat(ACT_CALIBRATE, SAMPLE_W'($urandom()));
        sent += len;
      end
    end
  endtask

  // Edge values, calibrate on empty and partly filled windows, wide fill bits
  task automatic test_directed();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    send_beat(ACT_CALIBRATE, 12'hFFF);
    send_beat(ACT_SAMPLE, 12'hFFF);
    send_beat(ACT_SAMPLE, 12'h000);
    send_beat(ACT_SAMPLE, 12'h001);
    send_beat(ACT_SAMPLE, 12'h800, 4'hF);
    send_beat(ACT_CALIBRATE, 12'h555);
    send_beat(ACT_SAMPLE, 12'h000);
    send_beat(ACT_SAMPLE, 12'hAAA);
    send_beat(ACT_SAMPLE, 12'h555);
    set_scale(32'h0000_FFFF);
    for (int i = 0; i < 6; i++) send_beat(ACT_SAMPLE, 12'hFFF);
    send_beat(ACT_CALIBRATE, 12'h000);
    send_beat(ACT_SAMPLE, 12'h000);
    send_beat(ACT_SAMPLE, 12'h7FF);
    send_beat(ACT_CALIBRATE, 12'hFFF);
    send_beat(ACT_SAMPLE, 12'h001);
  endtask

  // Writes to an unused index must leave the scale alone
  task automatic test_register_map();
    wait_drained();
    cfg_write(ADDR_UNUSED, 32'h0000_1234);
    cfg_check_scale();
    set_scale({16'hDEAD, SCALE_RESET});
    cfg_write(ADDR_UNUSED, 32'hFFFF_FFFF);
    cfg_check_scale();
    for (int i = 0; i < 5; i++) send_beat(ACT_SAMPLE, SAMPLE_W'($urandom()));
    send_beat(ACT_CALIBRATE, '0);
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                   input logic [CFG_W-1:0] scale, input int n_items);
    set_scale(scale);
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    run_traffic(n_items);
  endtask

  // Hold the receiver off long enough to fill the block and stall its input
  task automatic test_output_backpressure();
    set_scale(SCALE_RESET);
    in_idle_pct   = 0;
    out_stall_pct = 0;
    hold_asked    = hold_asked + 1;
    run_traffic(24);
  endtask

  // Let the block drain fully mid-stream, then resume
  task automatic test_drain_pause();
    in_idle_pct   = 20;
    out_stall_pct = 20;
    run_traffic(30);
    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk);
    run_traffic(30);
  endtask

  // Drive the receiver ready; a requested hold-off is counted here
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_asked != hold_taken) begin
      hold_taken <= hold_asked;
      hold_left  <= HOLD_CYC;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // Compare each result beat with the oldest pending reading
  always @(posedge clk) begin
    airspeed_reading_t exp_rd;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_readings.size() == 0) begin
        $error("result beat with no reading pending: tdata %h", out_tdata);
        error_count++;
      end else begin
        exp_rd = pending_readings.pop_front();
        if (out_tdata[SPEED_W-1:0] !== exp_rd.speed) begin
          $error("speed: expected %0d, actual %0d", exp_rd.speed, out_tdata[SPEED_W-1:0]);
          error_count++;
        end
        if (out_tdata[SPEED_W +: SAMPLE_W] !== exp_rd.zero_offset) begin
          $error("zero_offset: expected %0d, actual %0d",
                 exp_rd.zero_offset, out_tdata[SPEED_W +: SAMPLE_W]);
          error_count++;
        end
      end
    end
  end

  // End the run when nothing has moved for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_pitot_airspeed_window_average_top: done, errors");
      $finish;
    end
  end

  initial begin
    clear_airspeed_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_register_map();
    test_random_phase(0, 0, 32'h0000_FFFF, 250);
    test_output_backpressure();
    test_random_phase(55, 0, 32'h0000_0000, 250);
    test_random_phase(0, 55, 32'h0000_0001, 250);
    test_drain_pause();
    test_random_phase(36, 36, $urandom(), 250);
    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk);
    if (error_count == 0)
      $display("tb_pitot_airspeed_window_average_top: done, clean");
    else
      $display("tb_pitot_airspeed_window_average_top: done, errors");
    $finish;
  end

endmodule
